@@ src/jgc_pkg.sv @@
// shared types and constants for the jet / gray colormap core
// no dependencies; used by every module of the block by scoped name
`timescale 1ns / 1ps

package jgc_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;

  // reset value of the upper bound, truncated to the sample width
  localparam logic [31:0] MAX_RESET = 32'd32767;

  // slope of a jet ramp: floor(255 * 2 / 5) per unit of the scaled argument
  localparam logic [7:0] RAMP_GAIN = 8'd102;
  localparam logic [7:0] CH_FULL   = 8'd255;

  typedef enum logic [1:0] {
    MODE_JET   = 2'd0,
    MODE_GRAY  = 2'd1,
    MODE_WHITE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_MIN  = 2'd0,
    REG_MAX  = 2'd1,
    REG_MODE = 2'd2
  } reg_idx_t;

  // what travels beside the divider data in every cell
  typedef struct packed {
    logic [1:0] mode;
    logic       force_zero;
    logic       force_one;
  } side_t;

endpackage

@@ src/jgc_prep.sv @@
// entry stage: offsets the sample and the range, flags the clamped cases
// depends on jgc_pkg
`timescale 1ns / 1ps

module jgc_prep #(
  parameter int SAMPLE_WIDTH = jgc_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  logic [SAMPLE_WIDTH-1:0] min_value,
  input  logic [SAMPLE_WIDTH-1:0] max_value,
  input  logic [1:0]              map_mode,
  output logic                    valid_r,
  output logic [SAMPLE_WIDTH-1:0] rem_r,
  output logic [SAMPLE_WIDTH-1:0] den_r,
  output jgc_pkg::side_t          side_r
);

  logic signed [SAMPLE_WIDTH:0] num;
  logic signed [SAMPLE_WIDTH:0] den;
  logic                         zero_c;
  logic                         one_c;
  logic [SAMPLE_WIDTH-1:0]      rem_nxt;
  logic [SAMPLE_WIDTH-1:0]      den_nxt;
  jgc_pkg::side_t               side_nxt;

  always_comb begin
    num = $signed({sample[SAMPLE_WIDTH-1], sample})
        - $signed({min_value[SAMPLE_WIDTH-1], min_value});
    den = $signed({max_value[SAMPLE_WIDTH-1], max_value})
        - $signed({min_value[SAMPLE_WIDTH-1], min_value});
    zero_c = (den <= 0) || (num <= 0);
    one_c  = !zero_c && (num >= den);
    // clamped cases bypass the division, so start it from a clean remainder
    rem_nxt = (zero_c || one_c) ? '0 : num[SAMPLE_WIDTH-1:0];
    den_nxt = den[SAMPLE_WIDTH-1:0];
    side_nxt.mode       = map_mode;
    side_nxt.force_zero = zero_c;
    side_nxt.force_one  = one_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_nxt;
      side_r <= side_nxt;
    end
  end

endmodule

@@ src/jgc_div_cell.sv @@
// one restoring division cell: produces one quotient bit per transaction
// depends on jgc_pkg; chained by the top level, one cell per fraction bit
`timescale 1ns / 1ps

module jgc_div_cell #(
  parameter int SAMPLE_WIDTH = jgc_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = jgc_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_in,
  input  logic [SAMPLE_WIDTH-1:0] rem_in,
  input  logic [SAMPLE_WIDTH-1:0] den_in,
  input  logic [FRAC_BITS-1:0]    quo_in,
  input  jgc_pkg::side_t          side_in,
  output logic                    valid_r,
  output logic [SAMPLE_WIDTH-1:0] rem_r,
  output logic [SAMPLE_WIDTH-1:0] den_r,
  output logic [FRAC_BITS-1:0]    quo_r,
  output jgc_pkg::side_t          side_r
);

  logic [SAMPLE_WIDTH:0]   rem2;
  logic [SAMPLE_WIDTH:0]   diff;
  logic                    take;
  logic [SAMPLE_WIDTH-1:0] rem_nxt;
  logic [FRAC_BITS-1:0]    quo_nxt;

  always_comb begin
    rem2    = {rem_in, 1'b0};
    diff    = rem2 - {1'b0, den_in};
    take    = (rem2 >= {1'b0, den_in});
    rem_nxt = take ? diff[SAMPLE_WIDTH-1:0] : rem2[SAMPLE_WIDTH-1:0];
    quo_nxt = {quo_in[FRAC_BITS-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      den_r  <= den_in;
      quo_r  <= quo_nxt;
      side_r <= side_in;
    end
  end

endmodule

@@ src/jgc_colour.sv @@
// output stage: maps the fraction to red, green and blue and holds the result
// depends on jgc_pkg; fed by the last division cell
`timescale 1ns / 1ps

module jgc_colour #(
  parameter int FRAC_BITS = jgc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 valid_in,
  input  logic [FRAC_BITS-1:0] quo_in,
  input  jgc_pkg::side_t       side_in,
  output logic                 valid_r,
  output logic [7:0]           red_r,
  output logic [7:0]           green_r,
  output logic [7:0]           blue_r
);

  // argument scaled by 5 * one, which stays inside +-8 * one
  localparam int VW = FRAC_BITS + 6;
  localparam logic signed [VW-1:0] ONE_V   = VW'(1) << FRAC_BITS;
  localparam logic signed [VW-1:0] K3      = VW'((15 << FRAC_BITS) / 4);
  localparam logic signed [VW-1:0] K1      = VW'((5 << FRAC_BITS) / 4);
  localparam logic signed [VW-1:0] FIVE_V  = VW'(5) << FRAC_BITS;
  localparam logic signed [VW-1:0] THREE_V = VW'(3) << FRAC_BITS;

  function automatic logic [7:0] jet_ch(input logic signed [VW-1:0] v);
    logic [VW-1:0]   d;
    logic [VW+7:0]   prod;
    logic [7:0]      res;
    d    = '0;
    res  = '0;
    if (v <= -K3) begin
      res = '0;
    end else if (v <= -K1) begin
      d   = v + K3;
      prod = (VW+8)'(d) * (VW+8)'(jgc_pkg::RAMP_GAIN);
      res = prod[FRAC_BITS+7:FRAC_BITS];
    end else if (v <= K1) begin
      res = jgc_pkg::CH_FULL;
    end else if (v <= K3) begin
      d   = K3 - v;
      prod = (VW+8)'(d) * (VW+8)'(jgc_pkg::RAMP_GAIN);
      res = prod[FRAC_BITS+7:FRAC_BITS];
    end else begin
      res = '0;
    end
    return res;
  endfunction

  logic [FRAC_BITS:0]    frac;
  logic [FRAC_BITS+8:0]  gray_w;
  logic signed [VW-1:0]  x5;
  logic [7:0]            red_nxt;
  logic [7:0]            green_nxt;
  logic [7:0]            blue_nxt;

  always_comb begin
    if (side_in.force_one) begin
      frac = ONE_V[FRAC_BITS:0];
    end else if (side_in.force_zero) begin
      frac = '0;
    end else begin
      frac = {1'b0, quo_in};
    end
    // f * 255 as f * 256 - f
    gray_w = {frac, 8'd0} - {8'd0, frac};
    // 5 * (2f - 1)
    x5 = $signed({5'd0, frac} << 3) + $signed({5'd0, frac} << 1) - FIVE_V;

    case (side_in.mode)
      jgc_pkg::MODE_JET: begin
        red_nxt   = jet_ch(x5 - THREE_V);
        green_nxt = jet_ch(x5);
        blue_nxt  = jet_ch(x5 + THREE_V);
      end
      jgc_pkg::MODE_GRAY: begin
        red_nxt   = gray_w[FRAC_BITS+7:FRAC_BITS];
        green_nxt = gray_w[FRAC_BITS+7:FRAC_BITS];
        blue_nxt  = gray_w[FRAC_BITS+7:FRAC_BITS];
      end
      default: begin
        red_nxt   = jgc_pkg::CH_FULL;
        green_nxt = jgc_pkg::CH_FULL;
        blue_nxt  = jgc_pkg::CH_FULL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule

@@ src/jet_gray_colormap_core.sv @@
// top level of the jet / gray colormap core: config registers and the cell chain
// depends on jgc_pkg, jgc_prep, jgc_div_cell and jgc_colour
`timescale 1ns / 1ps
//
//   channel   direction  handshake             payload
//   in_       sink       in_valid / in_stall   in_sample
//   out_      source     out_valid / out_stall out_red, out_green, out_blue
//   cfg_      sink       cfg_we                cfg_index, cfg_wdata
//
// one transaction per cycle sustained while no blocked result freezes the chain; the chain is an entry
// stage, one division cell per fraction bit, and the colour output register.
// the whole chain advances together; it freezes only while a result sits in the
// output register with out_stall high, and in_stall is raised in exactly that case.
// rst_n (synchronous) empties the chain and restores the bounds and the mode.

module jet_gray_colormap_core #(
  parameter int SAMPLE_WIDTH = jgc_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = jgc_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [7:0]              out_red,
  output logic [7:0]              out_green,
  output logic [7:0]              out_blue,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [SAMPLE_WIDTH-1:0] cfg_wdata
);

  logic [SAMPLE_WIDTH-1:0] min_value_r;
  logic [SAMPLE_WIDTH-1:0] max_value_r;
  logic [1:0]              map_mode_r;
  logic                    en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r <= '0;
      max_value_r <= jgc_pkg::MAX_RESET[SAMPLE_WIDTH-1:0];
      map_mode_r  <= jgc_pkg::MODE_JET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jgc_pkg::REG_MIN:  min_value_r <= cfg_wdata;
        jgc_pkg::REG_MAX:  max_value_r <= cfg_wdata;
        jgc_pkg::REG_MODE: map_mode_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  logic                    valid_c [0:FRAC_BITS];
  logic [SAMPLE_WIDTH-1:0] rem_c   [0:FRAC_BITS];
  logic [SAMPLE_WIDTH-1:0] den_c   [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]    quo_c   [0:FRAC_BITS];
  jgc_pkg::side_t          side_c  [0:FRAC_BITS];

  jgc_prep #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .sample    (in_sample),
    .min_value (min_value_r),
    .max_value (max_value_r),
    .map_mode  (map_mode_r),
    .valid_r   (valid_c[0]),
    .rem_r     (rem_c[0]),
    .den_r     (den_c[0]),
    .side_r    (side_c[0])
  );

  assign quo_c[0] = '0;

  for (genvar i = 0; i < FRAC_BITS; i++) begin : g_cell
    jgc_div_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (valid_c[i]),
      .rem_in   (rem_c[i]),
      .den_in   (den_c[i]),
      .quo_in   (quo_c[i]),
      .side_in  (side_c[i]),
      .valid_r  (valid_c[i+1]),
      .rem_r    (rem_c[i+1]),
      .den_r    (den_c[i+1]),
      .quo_r    (quo_c[i+1]),
      .side_r   (side_c[i+1])
    );
  end

  jgc_colour #(
    .FRAC_BITS(FRAC_BITS)
  ) u_colour (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (valid_c[FRAC_BITS]),
    .quo_in   (quo_c[FRAC_BITS]),
    .side_in  (side_c[FRAC_BITS]),
    .valid_r  (out_valid),
    .red_r    (out_red),
    .green_r  (out_green),
    .blue_r   (out_blue)
  );

endmodule

@@ src/jgc_checker.sv @@
// port-level checks for the jet / gray colormap core, bound to the top level
// depends on jet_gray_colormap_core only through its port names
`timescale 1ns / 1ps

module jgc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  // a result waiting under stall stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its colour
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_red) && $stable(out_green)
                               && $stable(out_blue))
    else $error("stalled result changed");

  // the input side backs up only behind a blocked result
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  // an empty chain after reset offers nothing
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind jet_gray_colormap_core jgc_checker u_jgc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue)
);
